### design/cbd_pkg.sv
package cbd_pkg;

    localparam int RAM_DEPTH_DFLT = 2048;
    localparam int MIDQ_DEPTH     = 2;
    localparam int OUTQ_DEPTH     = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_TWO_BANKS = 2'd2;

    typedef enum logic [2:0] {
        TGT_RAM      = 3'd0,
        TGT_VIDEO    = 3'd1,
        TGT_IO       = 3'd2,
        TGT_CART     = 3'd3,
        TGT_INTERNAL = 3'd4
    } target_t;

    typedef struct packed {
        logic [7:0]  rdata;
        target_t     target;
        logic [4:0]  reg_index;
        logic [14:0] cart_offset;
        logic        ext_strobe;
        logic        dma_stall;
    } result_t;

    typedef struct packed {
        logic        wr;
        logic        ram_access;
        logic [15:0] addr;
        logic [7:0]  wdata;
        result_t     res;
    } item_t;

endpackage

### design/cpu_bus_decoder_with_code_patch_core.sv
// Channel   Handshake                    Words
// --------  ---------------------------  ---------------------------------------------
// access    push / full                  op, addr, wdata, ext_rdata
// result    empty / pop                  rdata, target, reg_index, cart_offset,
//                                        ext_strobe, dma_stall
// config    cfg_we (no wait)             cfg_index, cfg_wdata
//
// One word per cycle while pops keep up; words pass mid queue, issue reg, result queue.
// The single-port work RAM sets that rate: one read or write per cycle.
// After reset, full stays high while the RAM is zeroed.
// A 2-word queue parts decode from execution; a 4-word result queue absorbs pop stalls.
module cpu_bus_decoder_with_code_patch_core
    import cbd_pkg::*;
#(
    parameter int RAM_DEPTH = RAM_DEPTH_DFLT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  push,
    output logic                  full,
    input  logic                  op,
    input  logic [15:0]           addr,
    input  logic [7:0]            wdata,
    input  logic [7:0]            ext_rdata,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            rdata,
    output logic [2:0]            target,
    output logic [4:0]            reg_index,
    output logic [14:0]           cart_offset,
    output logic                  ext_strobe,
    output logic                  dma_stall
);

    localparam int MQW = $clog2(MIDQ_DEPTH+1);

    item_t          front_item;
    item_t          mid_item;
    logic           mid_full, mid_empty, mid_pop;
    logic [MQW-1:0] mid_count;
    logic           busy;
    result_t        res;

    assign full = mid_full || busy || (mid_count > MQW'(MIDQ_DEPTH));

    cbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .op        (op),
        .addr      (addr),
        .wdata     (wdata),
        .ext_rdata (ext_rdata),
        .item      (front_item)
    );

    cbd_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (MIDQ_DEPTH)
    ) u_midq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !full),
        .din   (front_item),
        .pop   (mid_pop),
        .dout  (mid_item),
        .full  (mid_full),
        .empty (mid_empty),
        .count (mid_count)
    );

    cbd_back #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_item  (mid_item),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .busy      (busy),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign rdata       = res.rdata;
    assign target      = 3'(res.target);
    assign reg_index   = res.reg_index;
    assign cart_offset = res.cart_offset;
    assign ext_strobe  = res.ext_strobe;
    assign dma_stall   = res.dma_stall;

endmodule

### design/cbd_fifo.sv
module cbd_fifo
    import cbd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign dout    = data_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### design/cbd_front.sv
module cbd_front
    import cbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  op,
    input  logic [15:0]           addr,
    input  logic [7:0]            wdata,
    input  logic [7:0]            ext_rdata,
    output item_t                 item
);

    localparam logic [2:0]  VREG_STATUS = 3'd2;
    localparam logic [2:0]  VREG_OAMDAT = 3'd4;
    localparam logic [2:0]  VREG_DATA   = 3'd7;
    localparam logic [15:0] IO_OAMDMA   = 16'h4014;
    localparam logic [15:0] IO_JOY1     = 16'h4016;
    localparam logic [15:0] IO_JOY2     = 16'h4017;
    localparam logic [10:0] IO_PAGE     = 11'h200;

    logic        patch_enable_reg;
    logic [23:0] patch_code_reg;
    logic        prg_two_banks_reg;

    logic [3:0]  d0, d1, d2, d3, d4, d5;
    logic [15:0] patch_addr;
    logic [7:0]  patch_data;
    logic        video_ok, io_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_enable_reg  <= 1'b0;
            patch_code_reg    <= '0;
            prg_two_banks_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATCH_ENABLE:  patch_enable_reg  <= cfg_wdata[0];
                CFG_PATCH_CODE:    patch_code_reg    <= cfg_wdata[23:0];
                CFG_PRG_TWO_BANKS: prg_two_banks_reg <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    assign d0 = patch_code_reg[3:0];
    assign d1 = patch_code_reg[7:4];
    assign d2 = patch_code_reg[11:8];
    assign d3 = patch_code_reg[15:12];
    assign d4 = patch_code_reg[19:16];
    assign d5 = patch_code_reg[23:20];

    assign patch_addr = {1'b1, d3[2:0], d4[3], d5[2:0], d1[3], d2[2:0], d3[3], d4[2:0]};
    assign patch_data = {d0[3], d1[2:0], d5[3], d0[2:0]};

    // write-only / read-only video registers answered internally
    assign video_ok = op ? (addr[2:0] != VREG_STATUS)
                         : (addr[2:0] == VREG_STATUS || addr[2:0] == VREG_OAMDAT ||
                            addr[2:0] == VREG_DATA);
    assign io_ok    = (addr == IO_JOY1) || (addr == IO_JOY2) || (op && addr == IO_OAMDMA);

    always_comb
    begin
        item                 = '0;
        item.wr              = op;
        item.addr            = addr;
        item.wdata           = wdata;
        item.res.target      = TGT_INTERNAL;
        priority if (!op && patch_enable_reg && addr == patch_addr)
        begin
            item.res.rdata = patch_data;
        end
        else if (addr[15:13] == 3'b000)
        begin
            item.ram_access = 1'b1;
            item.res.target = TGT_RAM;
        end
        else if (addr[15:14] == 2'b00)
        begin
            if (video_ok)
            begin
                item.res.target     = TGT_VIDEO;
                item.res.reg_index  = {2'b00, addr[2:0]};
                item.res.ext_strobe = 1'b1;
                item.res.rdata      = op ? 8'h00 : ext_rdata;
            end
        end
        else if (addr[15:5] == IO_PAGE)
        begin
            if (io_ok)
            begin
                item.res.target     = TGT_IO;
                item.res.reg_index  = addr[4:0];
                item.res.ext_strobe = 1'b1;
                item.res.rdata      = op ? 8'h00 : ext_rdata;
                item.res.dma_stall  = op && (addr == IO_OAMDMA);
            end
        end
        else if (addr[15] && !op)
        begin
            item.res.target      = TGT_CART;
            item.res.cart_offset = prg_two_banks_reg ? addr[14:0] : {1'b0, addr[13:0]};
            item.res.ext_strobe  = 1'b1;
            item.res.rdata       = ext_rdata;
        end
    end

endmodule

### design/cbd_back.sv
module cbd_back
    import cbd_pkg::*;
#(
    parameter int RAM_DEPTH = RAM_DEPTH_DFLT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t mid_item,
    input  logic  mid_empty,
    output logic  mid_pop,
    output logic  busy,
    input  logic  pop,
    output logic  empty,
    output result_t res
);

    localparam int AW = $clog2(RAM_DEPTH);
    localparam int QW = $clog2(OUTQ_DEPTH+1);

    logic [7:0]    ram [RAM_DEPTH];
    logic [7:0]    ram_q_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_idx_reg;
    logic          inflight_reg;
    logic          ram_rd_reg;
    result_t       held_reg;

    logic          issue, room;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [QW-1:0] out_count;
    logic          out_full;
    result_t       out_din;

    assign busy  = clr_busy_reg;
    assign room  = ((QW+1)'(out_count) + (QW+1)'(inflight_reg)) < (QW+1)'(OUTQ_DEPTH);
    assign issue = !clr_busy_reg && !mid_empty && room && !out_full;
    assign mid_pop = issue;

    assign ram_we    = clr_busy_reg || (issue && mid_item.ram_access && mid_item.wr);
    assign ram_re    = issue && mid_item.ram_access && !mid_item.wr;
    assign ram_waddr = clr_busy_reg ? clr_idx_reg : mid_item.addr[AW-1:0];
    assign ram_wdata = clr_busy_reg ? 8'h00 : mid_item.wdata;

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram[ram_waddr] <= ram_wdata;
        end
        if (ram_re)
        begin
            ram_q_reg <= ram[mid_item.addr[AW-1:0]];
        end
    end

    // zero the RAM after reset, one byte per cycle; also register the issue and RAM-read flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            inflight_reg <= 1'b0;
            ram_rd_reg   <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(RAM_DEPTH-1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            inflight_reg <= issue;
            ram_rd_reg   <= ram_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            held_reg <= mid_item.res;
        end
    end

    always_comb
    begin
        out_din = held_reg;
        if (ram_rd_reg)
        begin
            out_din.rdata = ram_q_reg;
        end
    end

    cbd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (inflight_reg),
        .din   (out_din),
        .pop   (pop),
        .dout  (res),
        .full  (out_full),
        .empty (empty),
        .count (out_count)
    );

endmodule

### verif/tb_cpu_bus_decoder_with_code_patch_core.sv
`timescale 1ns / 100ps

module tb_cpu_bus_decoder_with_code_patch_core;

    import cbd_pkg::*;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [2:0] VID_STATUS   = 3'd2;
    localparam logic [2:0] VID_OAM_DATA = 3'd4;
    localparam logic [2:0] VID_DATA     = 3'd7;

    localparam logic [15:0] IO_OAM_DMA = 16'h4014;
    localparam logic [15:0] IO_PAD1    = 16'h4016;
    localparam logic [15:0] IO_PAD2    = 16'h4017;

    localparam result_t NO_WORD = '0;

    typedef enum logic {ROW_ACCESS, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  o;
        logic [15:0]           a;
        logic [7:0]            wd;
        logic [7:0]            ext;
        logic                  typed;
        result_t               want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  push;
    logic                  full;
    logic                  op;
    logic [15:0]           addr;
    logic [7:0]            wdata;
    logic [7:0]            ext_rdata;
    logic                  empty;
    logic                  pop;
    logic [7:0]            rdata;
    logic [2:0]            target;
    logic [4:0]            reg_index;
    logic [14:0]           cart_offset;
    logic                  ext_strobe;
    logic                  dma_stall;

    logic [7:0]            work_ram_img [RAM_DEPTH_DFLT];
    logic                  patch_on;
    logic [23:0]           patch_word;
    logic                  two_banks;

    result_t               pending_bus_results [$];
    stim_row_t             stim_rows [$];
    logic                  idle_on;
    int                    rx_hold_cycles;
    int                    mismatches;

    cpu_bus_decoder_with_code_patch_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .full        (full),
        .op          (op),
        .addr        (addr),
        .wdata       (wdata),
        .ext_rdata   (ext_rdata),
        .empty       (empty),
        .pop         (pop),
        .rdata       (rdata),
        .target      (target),
        .reg_index   (reg_index),
        .cart_offset (cart_offset),
        .ext_strobe  (ext_strobe),
        .dma_stall   (dma_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [15:0] patch_addr();
        return {1'b1, patch_word[14:12], patch_word[19], patch_word[22:20],
                patch_word[7], patch_word[10:8], patch_word[15], patch_word[18:16]};
    endfunction

    function automatic logic [7:0] patch_byte();
        return {patch_word[3], patch_word[6:4], patch_word[23], patch_word[2:0]};
    endfunction

    function automatic result_t decode_access(input logic wr, input logic [15:0] a,
                                              input logic [7:0] wd, input logic [7:0] ext);
        result_t r;
        logic    ok;
        r = '0;
        r.target = TGT_INTERNAL;
        if (wr == OP_READ && patch_on && a == patch_addr())
            r.rdata = patch_byte();
        else if (a < 16'h2000)
        begin
            r.target = TGT_RAM;
            if (wr == OP_WRITE)
                work_ram_img[a[10:0]] = wd;
            else
                r.rdata = work_ram_img[a[10:0]];
        end
        else if (a < 16'h4000)
        begin
            if (wr == OP_WRITE)
                ok = (a[2:0] != VID_STATUS);
            else
                ok = (a[2:0] == VID_STATUS || a[2:0] == VID_OAM_DATA || a[2:0] == VID_DATA);
            if (ok)
            begin
                r.target     = TGT_VIDEO;
                r.reg_index  = {2'b00, a[2:0]};
                r.ext_strobe = 1'b1;
                if (wr == OP_READ)
                    r.rdata = ext;
            end
        end
        else if (a < 16'h4020)
        begin
            ok = (a == IO_PAD1 || a == IO_PAD2) || (wr == OP_WRITE && a == IO_OAM_DMA);
            if (ok)
            begin
                r.target     = TGT_IO;
                r.reg_index  = a[4:0];
                r.ext_strobe = 1'b1;
                r.dma_stall  = (wr == OP_WRITE && a == IO_OAM_DMA);
                if (wr == OP_READ)
                    r.rdata = ext;
            end
        end
        else if (a >= 16'h8000 && wr == OP_READ)
        begin
            r.target      = TGT_CART;
            r.cart_offset = two_banks ? a[14:0] : {1'b0, a[13:0]};
            r.ext_strobe  = 1'b1;
            r.rdata       = ext;
        end
        return r;
    endfunction

    function automatic result_t word_of(input logic [7:0] rd, input target_t tgt,
                                        input logic [4:0] ri, input logic [14:0] co,
                                        input logic st, input logic ds);
        result_t r;
        r.rdata       = rd;
        r.target      = tgt;
        r.reg_index   = ri;
        r.cart_offset = co;
        r.ext_strobe  = st;
        r.dma_stall   = ds;
        return r;
    endfunction

    function automatic void add_access(input logic o, input logic [15:0] a,
                                       input logic [7:0] wd, input logic [7:0] ext,
                                       input logic typed, input result_t want);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_ACCESS;
        row.o     = o;
        row.a     = a;
        row.wd    = wd;
        row.ext   = ext;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        stim_rows.push_back(row);
    endfunction

    task automatic send_word(input logic o, input logic [15:0] a, input logic [7:0] wd,
                             input logic [7:0] ext, input logic typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push      <= 1'b1;
        op        <= o;
        addr      <= a;
        wdata     <= wd;
        ext_rdata <= ext;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        predicted = decode_access(o, a, wd, ext);
        pending_bus_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        push <= 1'b0;
        while (pending_bus_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PATCH_ENABLE:  patch_on   = val[0];
            CFG_PATCH_CODE:    patch_word = val;
            CFG_PRG_TWO_BANKS: two_banks  = val[0];
            default: ;
        endcase
    endtask

    // result side
    initial
    begin
        int      gap;
        result_t want;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (rx_hold_cycles > 0)
            begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty !== 1'b0)
                @(posedge clk);
            if (pending_bus_results.size() == 0)
            begin
                $error("unexpected result word: rdata %0h target %0d", rdata, target);
                mismatches++;
            end
            else
            begin
                want = pending_bus_results.pop_front();
                if (rdata !== want.rdata)
                begin
                    $error("rdata: expected %0h, got %0h", want.rdata, rdata);
                    mismatches++;
                end
                if (target !== want.target)
                begin
                    $error("target: expected %0d, got %0d", want.target, target);
                    mismatches++;
                end
                if (reg_index !== want.reg_index)
                begin
                    $error("reg_index: expected %0d, got %0d", want.reg_index, reg_index);
                    mismatches++;
                end
                if (cart_offset !== want.cart_offset)
                begin
                    $error("cart_offset: expected %0h, got %0h", want.cart_offset, cart_offset);
                    mismatches++;
                end
                if (ext_strobe !== want.ext_strobe)
                begin
                    $error("ext_strobe: expected %0b, got %0b", want.ext_strobe, ext_strobe);
                    mismatches++;
                end
                if (dma_stall !== want.dma_stall)
                begin
                    $error("dma_stall: expected %0b, got %0b", want.dma_stall, dma_stall);
                    mismatches++;
                end
            end
        end
    end

    // access side
    initial
    begin
        int          n;
        int          p;
        int          sel;
        logic        o;
        logic [15:0] a;
        logic [7:0]  wd;
        logic [7:0]  ext;
        logic [23:0] code_v;

        rst_n          = 1'b0;
        push           = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        op             = OP_READ;
        addr           = '0;
        wdata          = '0;
        ext_rdata      = '0;
        idle_on        = 1'b1;
        rx_hold_cycles = 0;
        mismatches     = 0;
        patch_on       = 1'b0;
        patch_word     = '0;
        two_banks      = 1'b1;
        foreach (work_ram_img[i])
            work_ram_img[i] = 8'h00;

        add_access(OP_READ,  16'h0000, 8'h00, 8'h00, 1'b1,
                   word_of(8'h00, TGT_RAM, 5'd0, 15'd0, 1'b0, 1'b0));
        add_access(OP_WRITE, 16'h0000, 8'hFF, 8'h00, 1'b1,
                   word_of(8'h00, TGT_RAM, 5'd0, 15'd0, 1'b0, 1'b0));
        add_access(OP_READ,  16'h1800, 8'h00, 8'h00, 1'b0, NO_WORD);
        add_access(OP_WRITE, 16'h07FF, 8'hA5, 8'h00, 1'b0, NO_WORD);
        add_access(OP_READ,  16'h1FFF, 8'h00, 8'h00, 1'b0, NO_WORD);
        add_access(OP_READ,  16'h2002, 8'h00, 8'h80, 1'b1,
                   word_of(8'h80, TGT_VIDEO, 5'd2, 15'd0, 1'b1, 1'b0));
        add_access(OP_READ,  16'h2000, 8'h00, 8'h5A, 1'b1,
                   word_of(8'h00, TGT_INTERNAL, 5'd0, 15'd0, 1'b0, 1'b0));
        add_access(OP_WRITE, 16'h3FFA, 8'h33, 8'h00, 1'b1,
                   word_of(8'h00, TGT_INTERNAL, 5'd0, 15'd0, 1'b0, 1'b0));
        add_access(OP_READ,  16'h3FFC, 8'h00, 8'hC3, 1'b0, NO_WORD);
        add_access(OP_READ,  16'h2007, 8'h00, 8'h3C, 1'b0, NO_WORD);
        add_access(OP_WRITE, 16'h2006, 8'h77, 8'h00, 1'b0, NO_WORD);
        add_access(OP_WRITE, 16'h4014, 8'h02, 8'h00, 1'b1,
                   word_of(8'h00, TGT_IO, 5'd20, 15'd0, 1'b1, 1'b1));
        add_access(OP_READ,  16'h4014, 8'h00, 8'h99, 1'b1,
                   word_of(8'h00, TGT_INTERNAL, 5'd0, 15'd0, 1'b0, 1'b0));
        add_access(OP_READ,  16'h4016, 8'h00, 8'h41, 1'b1,
                   word_of(8'h41, TGT_IO, 5'd22, 15'd0, 1'b1, 1'b0));
        add_access(OP_WRITE, 16'h4017, 8'h01, 8'h00, 1'b0, NO_WORD);
        add_access(OP_READ,  16'h4000, 8'h00, 8'hFF, 1'b1,
                   word_of(8'h00, TGT_INTERNAL, 5'd0, 15'd0, 1'b0, 1'b0));
        add_access(OP_WRITE, 16'h401F, 8'hFF, 8'h00, 1'b1,
                   word_of(8'h00, TGT_INTERNAL, 5'd0, 15'd0, 1'b0, 1'b0));
        add_access(OP_READ,  16'h4020, 8'h00, 8'hFF, 1'b1,
                   word_of(8'h00, TGT_INTERNAL, 5'd0, 15'd0, 1'b0, 1'b0));
        add_access(OP_WRITE, 16'h7FFF, 8'hFF, 8'h00, 1'b1,
                   word_of(8'h00, TGT_INTERNAL, 5'd0, 15'd0, 1'b0, 1'b0));
        add_access(OP_READ,  16'h8000, 8'h00, 8'h00, 1'b1,
                   word_of(8'h00, TGT_CART, 5'd0, 15'h0000, 1'b1, 1'b0));
        add_access(OP_READ,  16'hFFFF, 8'h00, 8'hFF, 1'b1,
                   word_of(8'hFF, TGT_CART, 5'd0, 15'h7FFF, 1'b1, 1'b0));
        add_access(OP_WRITE, 16'hC000, 8'h55, 8'h00, 1'b1,
                   word_of(8'h00, TGT_INTERNAL, 5'd0, 15'd0, 1'b0, 1'b0));
        // all-zero code lands on 0x8000 with a zero byte
        add_reg_write(CFG_PATCH_CODE, 24'h000000);
        add_reg_write(CFG_PATCH_ENABLE, 24'h000001);
        add_access(OP_READ,  16'h8000, 8'h00, 8'hAA, 1'b1,
                   word_of(8'h00, TGT_INTERNAL, 5'd0, 15'd0, 1'b0, 1'b0));
        add_access(OP_WRITE, 16'h8000, 8'h66, 8'h00, 1'b1,
                   word_of(8'h00, TGT_INTERNAL, 5'd0, 15'd0, 1'b0, 1'b0));
        add_reg_write(CFG_PATCH_CODE, 24'hFFFFFF);
        add_access(OP_READ,  16'hFFFF, 8'h00, 8'h12, 1'b1,
                   word_of(8'hFF, TGT_INTERNAL, 5'd0, 15'd0, 1'b0, 1'b0));
        add_reg_write(CFG_PATCH_ENABLE, 24'h000000);
        add_reg_write(CFG_PRG_TWO_BANKS, 24'h000000);
        add_access(OP_READ,  16'hC123, 8'h00, 8'h12, 1'b1,
                   word_of(8'h12, TGT_CART, 5'd0, 15'h0123, 1'b1, 1'b0));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_REG)
            begin
                wait_drain();
                write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            end
            else
                send_word(stim_rows[i].o, stim_rows[i].a, stim_rows[i].wd, stim_rows[i].ext,
                          stim_rows[i].typed, stim_rows[i].want);
        end

        for (p = 0; p < 8; p++)
        begin
            wait_drain();
            if (p == 1)
                code_v = 24'h000000;
            else if (p == 2)
                code_v = 24'hFFFFFF;
            else
                code_v = 24'($urandom);
            write_reg(CFG_PATCH_ENABLE, (p == 0) ? 24'd0 : 24'($urandom_range(0, 3) != 0));
            write_reg(CFG_PATCH_CODE, code_v);
            write_reg(CFG_PRG_TWO_BANKS, 24'(p % 2));
            idle_on = (p == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);

            // fill the queues against a stalled receiver
            if (p == 4)
            begin
                rx_hold_cycles = 60;
                for (n = 0; n < 40; n++)
                    send_word(OP_READ, {1'b1, 15'($urandom)}, 8'h00, 8'($urandom), 1'b0, NO_WORD);
                wait_drain();
            end

            for (n = 0; n < 225; n++)
            begin
                sel = $urandom_range(0, 99);
                o   = 1'($urandom_range(0, 1));
                wd  = 8'($urandom);
                ext = 8'($urandom);
                if (sel < 30)
                    a = {3'b000, 2'($urandom_range(0, 3)),
                         11'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 2047))};
                else if (sel < 48)
                    a = {3'b001, 13'($urandom)};
                else if (sel < 63)
                begin
                    case ($urandom_range(0, 3))
                        0:       a = IO_OAM_DMA;
                        1:       a = IO_PAD1;
                        2:       a = IO_PAD2;
                        default: a = {11'h200, 5'($urandom)};
                    endcase
                end
                else if (sel < 70)
                    a = 16'($urandom_range(16'h4020, 16'h7FFF));
                else if (sel < 88)
                    a = {1'b1, 15'($urandom)};
                else if (sel < 95)
                begin
                    a = patch_addr();
                    o = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_READ;
                end
                else
                    a = 16'($urandom);
                send_word(o, a, wd, ext, 1'b0, NO_WORD);
            end
        end

        wait_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
